[hw/rtl/epa_pkg.sv]
// ----------------------------------------------------------------------------
// Exponential priority aging package
// Item types, register map and fixed-point constants shared by the design.
// ----------------------------------------------------------------------------
package epa_pkg;

    typedef struct packed {
        logic [2:0]         queue_in;
        logic [31:0]        arrival;
        logic [31:0]        now;
        logic signed [47:0] score_in;
        logic               guaranteed_in;
    } epa_in_t;

    typedef struct packed {
        logic [31:0]        wait_res;
        logic signed [47:0] score_out;
        logic [2:0]         queue_out;
        logic               guaranteed_out;
        logic               promoted;
    } epa_out_t;

    // Per-item values that travel beside the exponential datapath.
    typedef struct packed {
        logic [31:0]        wait_val;
        logic signed [47:0] score;
        logic [2:0]         queue;
        logic               guar;
        logic               promote;
        logic               age_en;
        logic               sat;
        logic [4:0]         k;
    } epa_side_t;

    typedef enum logic [2:0] {
        REG_BOOST_GAIN  = 3'd0,
        REG_INV_Q1      = 3'd1,
        REG_INV_Q2      = 3'd2,
        REG_INV_Q3      = 3'd3,
        REG_INV_Q4      = 3'd4,
        REG_MAX_WAIT_Q2 = 3'd5,
        REG_MAX_WAIT_Q3 = 3'd6,
        REG_MAX_WAIT_Q4 = 3'd7
    } epa_reg_idx_t;

    localparam int ADDR_W = 5;

    localparam logic [2:0] QUEUE_EMERGENCY = 3'd0;
    localparam logic [2:0] QUEUE_CRITICAL  = 3'd1;
    localparam logic [2:0] QUEUE_LOW_A     = 3'd2;
    localparam logic [2:0] QUEUE_DEFAULT   = 3'd3;
    localparam logic [2:0] QUEUE_LOW_C     = 3'd4;

    localparam logic [18:0] GAIN_RESET  = 19'd6554;
    localparam logic [23:0] LN2_Q24     = 24'd11629080;
    localparam logic [24:0] ONE_Q24     = 25'd16777216;
    // floor(2^32 / ln2 in Q.24); the quotient estimate is at most one low.
    localparam logic [8:0]  LN2_RECIP   = 9'd369;
    localparam int          TERMS       = 9;
    localparam logic signed [47:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;

    // floor(2^26 / n) for the Taylor divisors.
    localparam logic [26:0] DIV_RECIP [1:TERMS] = '{
        27'd67108864, 27'd33554432, 27'd22369621, 27'd16777216, 27'd13421772,
        27'd11184810, 27'd9586980,  27'd8388608,  27'd7456540
    };

endpackage

[hw/rtl/exponential_priority_aging.sv]
// ----------------------------------------------------------------------------
// Exponential priority aging
// Raises a waiting operation's score by gain * exp(wait / tau) and promotes
// operations that waited past their queue's limit.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  request  | req_valid, req_stall, req_item   | in
//  response | rsp_valid, rsp_stall, rsp_item   | out
//  config   | psel, penable, pwrite, paddr,    | in/out
//           | pwdata, prdata, pready           |
//
// One item enters per cycle while the result is not stalled; the nine Taylor
// terms of the exponential take three stages each.
// Reset clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module exponential_priority_aging
    import epa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  epa_in_t           req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output epa_out_t          rsp_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [18:0] gain_reg;
    logic [23:0] inv_q1_reg, inv_q2_reg, inv_q3_reg, inv_q4_reg;
    logic [31:0] limit_q2_reg, limit_q3_reg, limit_q4_reg;
    epa_reg_idx_t reg_idx;

    logic adv;

    logic        s1_valid_reg;
    epa_side_t   s1_side_reg;
    logic [23:0] s1_inv_reg;
    logic [31:0] s1_limit_reg;
    logic        s1_pen_reg;

    logic        s2_valid_reg;
    epa_side_t   s2_side_reg;
    logic [55:0] s2_x_reg;

    logic        s3_valid_reg;
    epa_side_t   s3_side_reg;
    logic [27:0] s3_xs_reg;

    logic        s4_valid_reg;
    epa_side_t   s4_side_reg;
    logic [24:0] s4_r0_reg;

    logic        ta_valid_reg [1:TERMS];
    epa_side_t   ta_side_reg  [1:TERMS];
    logic [23:0] ta_p_reg     [1:TERMS];
    logic [23:0] ta_r_reg     [1:TERMS];
    logic [25:0] ta_e_reg     [1:TERMS];

    logic        tb_valid_reg [1:TERMS];
    epa_side_t   tb_side_reg  [1:TERMS];
    logic [23:0] tb_p_reg     [1:TERMS];
    logic [23:0] tb_q_reg     [1:TERMS];
    logic [23:0] tb_r_reg     [1:TERMS];
    logic [25:0] tb_e_reg     [1:TERMS];

    logic        tc_valid_reg [0:TERMS];
    epa_side_t   tc_side_reg  [0:TERMS];
    logic [24:0] tc_term_reg  [0:TERMS];
    logic [23:0] tc_r_reg     [0:TERMS];
    logic [25:0] tc_e_reg     [0:TERMS];

    logic        f1_valid_reg;
    epa_side_t   f1_side_reg;
    logic [31:0] f1_exp_reg;

    logic        f2_valid_reg;
    epa_side_t   f2_side_reg;
    logic [34:0] f2_boost_reg;

    logic        out_valid_reg;
    epa_out_t    out_item_reg;

    assign adv       = !(out_valid_reg && rsp_stall);
    assign req_stall = !adv;
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;
    assign pready    = 1'b1;
    assign reg_idx   = epa_reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            inv_q1_reg   <= '0;
            inv_q2_reg   <= '0;
            inv_q3_reg   <= '0;
            inv_q4_reg   <= '0;
            limit_q2_reg <= '1;
            limit_q3_reg <= '1;
            limit_q4_reg <= '1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_BOOST_GAIN:  gain_reg     <= pwdata[18:0];
                REG_INV_Q1:      inv_q1_reg   <= pwdata[23:0];
                REG_INV_Q2:      inv_q2_reg   <= pwdata[23:0];
                REG_INV_Q3:      inv_q3_reg   <= pwdata[23:0];
                REG_INV_Q4:      inv_q4_reg   <= pwdata[23:0];
                REG_MAX_WAIT_Q2: limit_q2_reg <= pwdata;
                REG_MAX_WAIT_Q3: limit_q3_reg <= pwdata;
                REG_MAX_WAIT_Q4: limit_q4_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BOOST_GAIN:  prdata = {13'd0, gain_reg};
            REG_INV_Q1:      prdata = {8'd0, inv_q1_reg};
            REG_INV_Q2:      prdata = {8'd0, inv_q2_reg};
            REG_INV_Q3:      prdata = {8'd0, inv_q3_reg};
            REG_INV_Q4:      prdata = {8'd0, inv_q4_reg};
            REG_MAX_WAIT_Q2: prdata = limit_q2_reg;
            REG_MAX_WAIT_Q3: prdata = limit_q3_reg;
            REG_MAX_WAIT_Q4: prdata = limit_q4_reg;
        endcase
    end

    // Stage 1: wait time and queue settings.
    logic [32:0] diff_next;
    logic [2:0]  sel_next;
    logic [23:0] inv_next;
    logic [31:0] limit_next;
    epa_side_t   s1_side_next;

    always_comb
    begin
        diff_next = {1'b0, req_item.now} - {1'b0, req_item.arrival};
        sel_next  = (req_item.queue_in > QUEUE_LOW_C) ? QUEUE_DEFAULT : req_item.queue_in;
        unique case (sel_next)
            QUEUE_CRITICAL: inv_next = inv_q1_reg;
            QUEUE_LOW_A:    inv_next = inv_q2_reg;
            QUEUE_DEFAULT:  inv_next = inv_q3_reg;
            QUEUE_LOW_C:    inv_next = inv_q4_reg;
            default:        inv_next = '0;
        endcase
        unique case (sel_next)
            QUEUE_LOW_A:    limit_next = limit_q2_reg;
            QUEUE_DEFAULT:  limit_next = limit_q3_reg;
            QUEUE_LOW_C:    limit_next = limit_q4_reg;
            default:        limit_next = '1;
        endcase
        s1_side_next          = '0;
        s1_side_next.wait_val = diff_next[32] ? 32'd0 : diff_next[31:0];
        s1_side_next.score    = req_item.score_in;
        s1_side_next.queue    = req_item.queue_in;
        s1_side_next.guar     = req_item.guaranteed_in;
        s1_side_next.age_en   = (inv_next != 24'd0);
    end

    // Stage 2: x = wait * inverse time constant, promotion check.
    epa_side_t s2_side_next;

    always_comb
    begin
        s2_side_next         = s1_side_reg;
        s2_side_next.promote = s1_pen_reg && (s1_side_reg.wait_val > s1_limit_reg);
    end

    // Stage 3: saturation test and estimate of k = x / ln2.
    logic [36:0] kest_prod_next;
    epa_side_t   s3_side_next;

    always_comb
    begin
        kest_prod_next   = 37'(s2_x_reg[27:0]) * 37'(LN2_RECIP);
        s3_side_next     = s2_side_reg;
        s3_side_next.sat = (s2_x_reg[55:28] != 28'd0) || (s2_x_reg[27:26] == 2'b11);
        s3_side_next.k   = kest_prod_next[36:32];
    end

    // Stage 4: remainder for the estimated k.
    logic [27:0] r0_next;

    always_comb
    begin
        r0_next = s3_xs_reg - 28'(s3_side_reg.k * LN2_Q24);
    end

    // Stage 5: correct k when the estimate was one low.
    epa_side_t   s5_side_next;
    logic [24:0] r5_next;

    always_comb
    begin
        s5_side_next = s4_side_reg;
        r5_next      = s4_r0_reg;
        if (s4_r0_reg >= 25'(LN2_Q24))
        begin
            r5_next        = s4_r0_reg - 25'(LN2_Q24);
            s5_side_next.k = s4_side_reg.k + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            tc_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= req_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            tc_valid_reg[0] <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg    <= s1_side_next;
            s1_inv_reg     <= inv_next;
            s1_limit_reg   <= limit_next;
            s1_pen_reg     <= !req_item.guaranteed_in && (sel_next >= QUEUE_LOW_A);
            s2_side_reg    <= s2_side_next;
            s2_x_reg       <= 56'(s1_side_reg.wait_val) * 56'(s1_inv_reg);
            s3_side_reg    <= s3_side_next;
            s3_xs_reg      <= s2_x_reg[27:0];
            s4_side_reg    <= s3_side_reg;
            s4_r0_reg      <= r0_next[24:0];
            tc_side_reg[0] <= s5_side_next;
            tc_term_reg[0] <= ONE_Q24;
            tc_r_reg[0]    <= r5_next[23:0];
            tc_e_reg[0]    <= 26'(ONE_Q24);
        end
    end

    // Taylor series of exp(r): each term is (term * r >> 24) / n.
    for (genvar n = 1; n <= TERMS; n++)
    begin : g_term
        logic [48:0] prod_next;
        logic [50:0] quot_next;
        logic [27:0] rem_next;
        logic [24:0] term_next;

        always_comb
        begin
            prod_next = 49'(tc_term_reg[n-1]) * 49'(tc_r_reg[n-1]);
            quot_next = 51'(ta_p_reg[n]) * 51'(DIV_RECIP[n]);
            rem_next  = 28'(tb_p_reg[n]) - 28'(tb_q_reg[n]) * 28'(n);
            term_next = (rem_next >= 28'(n)) ? 25'(tb_q_reg[n]) + 25'd1
                                             : 25'(tb_q_reg[n]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ta_valid_reg[n] <= 1'b0;
                tb_valid_reg[n] <= 1'b0;
                tc_valid_reg[n] <= 1'b0;
            end
            else if (adv)
            begin
                ta_valid_reg[n] <= tc_valid_reg[n-1];
                tb_valid_reg[n] <= ta_valid_reg[n];
                tc_valid_reg[n] <= tb_valid_reg[n];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ta_side_reg[n] <= tc_side_reg[n-1];
                ta_p_reg[n]    <= prod_next[47:24];
                ta_r_reg[n]    <= tc_r_reg[n-1];
                ta_e_reg[n]    <= tc_e_reg[n-1];
                tb_side_reg[n] <= ta_side_reg[n];
                tb_p_reg[n]    <= ta_p_reg[n];
                tb_q_reg[n]    <= quot_next[49:26];
                tb_r_reg[n]    <= ta_r_reg[n];
                tb_e_reg[n]    <= ta_e_reg[n];
                tc_side_reg[n] <= tb_side_reg[n];
                tc_term_reg[n] <= term_next;
                tc_r_reg[n]    <= tb_r_reg[n];
                tc_e_reg[n]    <= tb_e_reg[n] + 26'(term_next);
            end
        end
    end

    // Final scaling by 2^k into Q16.16, boost and saturating add.
    logic [42:0] shifted_next;
    logic [34:0] scaled_next;
    logic [31:0] exp_next;
    logic [50:0] boost_prod_next;
    logic [48:0] sum_next;
    epa_out_t    out_item_next;

    always_comb
    begin
        shifted_next = 43'(tc_e_reg[TERMS]) << tc_side_reg[TERMS].k;
        scaled_next  = shifted_next[42:8];
        if (tc_side_reg[TERMS].sat || (scaled_next[34:32] != 3'd0))
            exp_next = '1;
        else
            exp_next = scaled_next[31:0];

        boost_prod_next = 51'(gain_reg) * 51'(f1_exp_reg);

        sum_next = {f2_side_reg.score[47], f2_side_reg.score} + {14'd0, f2_boost_reg};
        out_item_next.wait_res = f2_side_reg.wait_val;
        if (!sum_next[48] && sum_next[47])
            out_item_next.score_out = SCORE_MAX;
        else
            out_item_next.score_out = sum_next[47:0];
        out_item_next.queue_out      = f2_side_reg.promote ? QUEUE_CRITICAL : f2_side_reg.queue;
        out_item_next.guaranteed_out = f2_side_reg.promote || f2_side_reg.guar;
        out_item_next.promoted       = f2_side_reg.promote;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg  <= tc_valid_reg[TERMS];
            f2_valid_reg  <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_side_reg  <= tc_side_reg[TERMS];
            f1_exp_reg   <= exp_next;
            f2_side_reg  <= f1_side_reg;
            f2_boost_reg <= f1_side_reg.age_en ? boost_prod_next[50:16] : 35'd0;
            out_item_reg <= out_item_next;
        end
    end

endmodule

[bench/exponential_priority_aging_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential priority aging testbench
// Drives aging requests under a range of register settings. A short table
// covers the reset state, the field extremes and each queue rule. Random
// items follow, with bursty input and a stalling receiver. Each result
// is checked against the row's own expectation or a cycle-free predictor
// of the wait, the boost and the promotion.
// ----------------------------------------------------------------------------
module exponential_priority_aging_tb;
    import epa_pkg::*;

    localparam logic [2:0] QUEUE_TOP   = 3'd7;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 104;
    localparam int         DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [18:0] gain;
        logic [23:0] inv1;
        logic [23:0] inv2;
        logic [23:0] inv3;
        logic [23:0] inv4;
        logic [31:0] lim2;
        logic [31:0] lim3;
        logic [31:0] lim4;
    } aging_setting_t;

    typedef struct {
        int       setting;
        bit       typed;
        epa_in_t  item;
        epa_out_t ex;
    } stim_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    epa_in_t           req_item  = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    epa_out_t          rsp_item;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic [18:0] gain_q16;
    logic [23:0] inv_tc [0:4];
    logic [31:0] wait_limit [0:4];

    epa_out_t  pending_results [$];
    stim_row_t stim_rows [$];

    int fail_cnt    = 0;
    int checked_cnt = 0;
    int promo_cnt   = 0;
    int sat_cnt     = 0;
    int setting_cnt = 1;
    int stall_cyc   = 0;
    int stall_mode  = 0;

    exponential_priority_aging DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] exp_q16_of(input logic [63:0] x);
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] v;
        if (x >= (64'd12 << 24))
            return 32'hFFFF_FFFF;
        k = x / 64'(LN2_Q24);
        r = x - k * 64'(LN2_Q24);
        e = 64'(ONE_Q24);
        term = 64'(ONE_Q24);
        for (int n = 1; n <= TERMS; n++)
        begin
            term = ((term * r) >> 24) / 64'(n);
            e = e + term;
        end
        v = (e << k) >> 8;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic epa_out_t aged_result(input epa_in_t it);
        epa_out_t    res;
        logic [31:0] wait_v;
        logic [2:0]  sel;
        logic [63:0] boost;
        longint      score;
        wait_v = (it.now >= it.arrival) ? it.now - it.arrival : 32'd0;
        sel = (it.queue_in > QUEUE_LOW_C) ? QUEUE_DEFAULT : it.queue_in;
        boost = '0;
        if (sel != QUEUE_EMERGENCY && inv_tc[sel] != 24'd0)
            boost = (64'(gain_q16) * 64'(exp_q16_of(64'(wait_v) * 64'(inv_tc[sel])))) >> 16;
        score = {{16{it.score_in[47]}}, it.score_in};
        score = score + longint'(boost);
        if (score > longint'(SCORE_MAX))
            score = longint'(SCORE_MAX);
        res.promoted = !it.guaranteed_in && sel >= QUEUE_LOW_A && wait_v > wait_limit[sel];
        res.wait_res = wait_v;
        res.score_out = score[47:0];
        res.queue_out = res.promoted ? QUEUE_CRITICAL : it.queue_in;
        res.guaranteed_out = res.promoted ? 1'b1 : it.guaranteed_in;
        return res;
    endfunction

    function automatic logic [23:0] pick_inv();
        case ($urandom_range(0, 3))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom_range(1, 16'hFFFF));
            default: return 24'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 5000));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic aging_setting_t pick_setting(input int phase);
        aging_setting_t c;
        if (phase == 0)
            c = '{19'd66, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0};
        else if (phase == 1)
            c = '{19'd327680, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        else
        begin
            case ($urandom_range(0, 2))
                0: c.gain = 19'd66;
                1: c.gain = 19'd327680;
                default: c.gain = 19'($urandom_range(66, 327680));
            endcase
            c.inv1 = pick_inv();
            c.inv2 = pick_inv();
            c.inv3 = pick_inv();
            c.inv4 = pick_inv();
            c.lim2 = pick_limit();
            c.lim3 = pick_limit();
            c.lim4 = pick_limit();
        end
        return c;
    endfunction

    function automatic epa_in_t random_item();
        epa_in_t     it;
        logic [2:0]  sel;
        logic [31:0] wait_v;
        logic [31:0] lim;
        logic [31:0] target;
        int unsigned off;
        it.queue_in = 3'($urandom_range(0, 7));
        sel = (it.queue_in > QUEUE_LOW_C) ? QUEUE_DEFAULT : it.queue_in;
        if (sel < QUEUE_LOW_A)
            lim = wait_limit[QUEUE_DEFAULT];
        else
            lim = wait_limit[sel];
        wait_v = 32'($urandom_range(0, 50));
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                target = 32'($urandom_range(0, 32'd218103808));
                if (inv_tc[sel] != 24'd0)
                    wait_v = target / 32'(inv_tc[sel]);
                else
                    wait_v = 32'($urandom_range(0, 1000));
            end
            4, 5:
            begin
                off = $urandom_range(0, 2);
                if (off == 0 && lim != 32'd0)
                    wait_v = lim - 32'd1;
                else if (off == 2 && lim != 32'hFFFF_FFFF)
                    wait_v = lim + 32'd1;
                else
                    wait_v = lim;
            end
            default: ;
        endcase
        it.arrival = 32'($urandom_range(0, 32'hFFFF_FFFF - wait_v));
        it.now = it.arrival + wait_v;
        case ($urandom_range(0, 9))
            6:
            begin
                it.arrival = $urandom;
                it.now = $urandom;
            end
            7:
            begin
                it.arrival = 32'($urandom_range(1, 32'hFFFF_FFFF));
                it.now = 32'($urandom_range(0, it.arrival - 32'd1));
            end
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: it.score_in = SCORE_MAX - 48'($urandom_range(0, 1048576));
            1: it.score_in = 48'h8000_0000_0000 + 48'($urandom_range(0, 1048576));
            default: it.score_in = 48'({$urandom, $urandom});
        endcase
        it.guaranteed_in = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    function automatic void add_row(input int setting, input epa_in_t it,
                                    input bit typed = 1'b0, input epa_out_t ex = '0);
        stim_row_t row;
        row.setting = setting;
        row.typed = typed;
        row.item = it;
        row.ex = ex;
        stim_rows.push_back(row);
    endfunction

    task automatic write_reg(input epa_reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_BOOST_GAIN:  gain_q16 = val[18:0];
            REG_INV_Q1:      inv_tc[1] = val[23:0];
            REG_INV_Q2:      inv_tc[2] = val[23:0];
            REG_INV_Q3:      inv_tc[3] = val[23:0];
            REG_INV_Q4:      inv_tc[4] = val[23:0];
            REG_MAX_WAIT_Q2: wait_limit[2] = val;
            REG_MAX_WAIT_Q3: wait_limit[3] = val;
            REG_MAX_WAIT_Q4: wait_limit[4] = val;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_setting(input aging_setting_t c);
        write_reg(REG_BOOST_GAIN, 32'(c.gain));
        write_reg(REG_INV_Q1, 32'(c.inv1));
        write_reg(REG_INV_Q2, 32'(c.inv2));
        write_reg(REG_INV_Q3, 32'(c.inv3));
        write_reg(REG_INV_Q4, 32'(c.inv4));
        write_reg(REG_MAX_WAIT_Q2, c.lim2);
        write_reg(REG_MAX_WAIT_Q3, c.lim3);
        write_reg(REG_MAX_WAIT_Q4, c.lim4);
        setting_cnt++;
    endtask

    task automatic send_item(input epa_in_t it, input bit typed, input epa_out_t ex);
        epa_out_t want;
        req_valid <= 1'b1;
        req_item <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = typed ? ex : aged_result(it);
        if (want.promoted)
            promo_cnt++;
        if (want.score_out == SCORE_MAX)
            sat_cnt++;
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic pause(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        stall_cyc++;
        if (stall_cyc % 150 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 2) != 0);
            default: rsp_stall <= (stall_cyc % 7 < 3);
        endcase
    end

    always @(posedge clk)
    begin
        epa_out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no request outstanding");
                fail_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_cnt++;
                if (rsp_item.wait_res !== want.wait_res)
                begin
                    $error("wait_res: expected %h, got %h", want.wait_res, rsp_item.wait_res);
                    fail_cnt++;
                end
                if (rsp_item.score_out !== want.score_out)
                begin
                    $error("score_out: expected %h, got %h", want.score_out, rsp_item.score_out);
                    fail_cnt++;
                end
                if (rsp_item.queue_out !== want.queue_out)
                begin
                    $error("queue_out: expected %0d, got %0d", want.queue_out, rsp_item.queue_out);
                    fail_cnt++;
                end
                if (rsp_item.guaranteed_out !== want.guaranteed_out)
                begin
                    $error("guaranteed_out: expected %b, got %b",
                           want.guaranteed_out, rsp_item.guaranteed_out);
                    fail_cnt++;
                end
                if (rsp_item.promoted !== want.promoted)
                begin
                    $error("promoted: expected %b, got %b", want.promoted, rsp_item.promoted);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("exponential_priority_aging_tb NOT OK");
        $finish;
    end

    initial
    begin
        aging_setting_t directed_setting;
        int             cur_setting;
        int             sent;
        int             burst;
        gain_q16 = GAIN_RESET;
        for (int i = 0; i < 5; i++)
        begin
            inv_tc[i] = 24'd0;
            wait_limit[i] = 32'hFFFF_FFFF;
        end
        directed_setting = '{19'd327680, 24'h00_0100, 24'd0, 24'hFF_FFFF, 24'h00_1000,
                             32'd100, 32'd1000, 32'd0};

        // Reset state: no queue ages and no limit can be passed.
        add_row(0, '{QUEUE_EMERGENCY, 32'd0, 32'd0, 48'd0, 1'b0}, 1'b1,
                '{32'd0, 48'd0, QUEUE_EMERGENCY, 1'b0, 1'b0});
        add_row(0, '{QUEUE_TOP, 32'd0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1}, 1'b1,
                '{32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, QUEUE_TOP, 1'b1, 1'b0});
        add_row(0, '{QUEUE_LOW_A, 32'hFFFF_FFFF, 32'd0, 48'h8000_0000_0000, 1'b0}, 1'b1,
                '{32'd0, 48'h8000_0000_0000, QUEUE_LOW_A, 1'b0, 1'b0});
        add_row(0, '{QUEUE_LOW_C, 32'd5, 32'd5, 48'hFFFF_FFFF_FFFF, 1'b0}, 1'b1,
                '{32'd0, 48'hFFFF_FFFF_FFFF, QUEUE_LOW_C, 1'b0, 1'b0});
        add_row(0, '{QUEUE_DEFAULT, 32'h1234_5678, 32'h9ABC_DEF0, 48'h0001_0000_0000, 1'b1},
                1'b1, '{32'h8888_8878, 48'h0001_0000_0000, QUEUE_DEFAULT, 1'b1, 1'b0});

        // Aging on except for queue LOW_A, with small limits: each queue rule in turn.
        add_row(1, '{QUEUE_EMERGENCY, 32'd0, 32'd1000000, 48'd0, 1'b0});
        add_row(1, '{QUEUE_CRITICAL, 32'd10, 32'd1010, 48'h1_0000, 1'b0});
        add_row(1, '{QUEUE_CRITICAL, 32'd0, 32'hFFFF_FFFF, 48'd0, 1'b0});
        add_row(1, '{QUEUE_LOW_A, 32'd0, 32'd200, 48'h5_0000, 1'b0});
        add_row(1, '{QUEUE_LOW_A, 32'd0, 32'd100, 48'h5_0000, 1'b0});
        add_row(1, '{QUEUE_DEFAULT, 32'd1000, 32'd1012, 48'd0, 1'b0});
        add_row(1, '{QUEUE_DEFAULT, 32'd0, 32'd13, 48'h7FFF_FFFF_0000, 1'b0});
        add_row(1, '{QUEUE_DEFAULT, 32'd0, 32'd13, 48'h8000_0000_0000, 1'b0});
        add_row(1, '{QUEUE_TOP, 32'd500, 32'd5, 48'hFFFF_FFFF_0000, 1'b0});
        add_row(1, '{QUEUE_TOP - 3'd1, 32'd0, 32'd2000, 48'd0, 1'b0});
        add_row(1, '{QUEUE_TOP - 3'd2, 32'd0, 32'd2000, 48'd0, 1'b1});
        add_row(1, '{QUEUE_LOW_C, 32'd7, 32'd8, 48'h1234_5678_9ABC, 1'b0});
        add_row(1, '{QUEUE_LOW_C, 32'd7, 32'd7, 48'h1234_5678_9ABC, 1'b0});
        add_row(1, '{QUEUE_LOW_C, 32'd0, 32'hFFFF_FFFF, 48'hEDCB_A987_6543, 1'b0});

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        cur_setting = 0;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].setting != cur_setting)
            begin
                settle();
                load_setting(directed_setting);
                cur_setting = stim_rows[i].setting;
            end
            send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].ex);
            if ($urandom_range(0, 3) == 0)
                pause($urandom_range(1, 3));
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            load_setting(pick_setting(phase));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                for (int j = 0; j < burst && sent < PHASE_ITEMS; j++)
                begin
                    send_item(random_item(), 1'b0, '0);
                    sent++;
                end
                if ($urandom_range(0, 2) != 0)
                    pause($urandom_range(1, 8));
            end
        end
        settle();

        $display("Checked %0d result items across %0d register settings.",
                 checked_cnt, setting_cnt);
        $display("Promotions seen: %0d; scores clipped at the maximum: %0d.",
                 promo_cnt, sat_cnt);
        if (fail_cnt == 0)
            $display("exponential_priority_aging_tb OK");
        else
            $display("exponential_priority_aging_tb NOT OK");
        $finish;
    end

endmodule
